FILE: rtl/core/b64enc_pkg.sv
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the alphabet lookup for the base64 encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

  localparam int unsigned CFG_W       = 13;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned SYM_W       = 6;
  localparam int unsigned CHARS_MAX   = 4;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [CFG_W-1:0]  OUT_LIMIT_RESET = 13'd128;
  localparam logic [CHAR_W-1:0] PAD_CHAR        = 7'h3D;
  localparam logic [CHAR_W-1:0] NO_CHAR         = 7'h00;

  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  // One encode request: up to four characters, drained in order.
  typedef struct packed {
    logic [CHARS_MAX-1:0][CHAR_W-1:0] chars;
    logic [IDX_W-1:0]                 last_idx;
    logic                             is_last;
    logic                             trunc;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [CHAR_W-1:0] sym(input logic [SYM_W-1:0] v);
    logic [CHAR_W-1:0] r;
    if (v < 6'd26) begin
      r = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'h61 + {1'b0, v - 6'd26};
    end else if (v < 6'd62) begin
      r = 7'h30 + {1'b0, v - 6'd52};
    end else if (v == 6'd62) begin
      r = 7'h2B;
    end else begin
      r = 7'h2F;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/b64enc_front.sv
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts bytes, tracks group phase, leftover bits and output count, and
// turns each byte into at most one packed character request for the back end.
// ----------------------------------------------------------------------------
module b64enc_front #(
  parameter int unsigned MAX_OUT_LIMIT = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [b64enc_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 data_byte,
  input  logic                       is_final,
  input  b64enc_pkg::q_status_t      q_stat,
  output logic                       push,
  output b64enc_pkg::job_t           push_job
);
  import b64enc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_OUT_LIMIT + 1);
  localparam int unsigned LIM_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
  localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_OUT_LIMIT);

  logic [CFG_W-1:0] out_limit;
  logic [1:0]       phase, phase_next;
  logic [3:0]       leftover, leftover_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             stopped, stopped_next;

  logic             accept;
  logic [LIM_W-1:0] lim_raw, lim, cnt_plus4;
  logic             stop_now;
  logic [SYM_W-1:0] s0, s1;
  logic [IDX_W-1:0] last_idx;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  assign lim_raw   = LIM_W'(out_limit);
  assign lim       = (lim_raw > MAX_LIM) ? MAX_LIM : lim_raw;
  assign cnt_plus4 = LIM_W'(cnt) + LIM_W'(4);
  assign stop_now  = !stopped && (phase == PHASE_FIRST) && (cnt_plus4 >= lim);

  always_comb begin
    phase_next    = phase;
    leftover_next = leftover;
    cnt_next      = cnt;
    stopped_next  = stopped;
    push          = 1'b0;
    s0            = '0;
    s1            = '0;
    last_idx      = '0;
    push_job.chars    = '0;
    push_job.last_idx = '0;
    push_job.is_last  = is_final;
    push_job.trunc    = 1'b0;

    case (phase)
      PHASE_FIRST: begin
        s0       = data_byte[7:2];
        s1       = {data_byte[1:0], 4'b0000};
        last_idx = is_final ? 2'd3 : 2'd0;
      end
      PHASE_SECOND: begin
        s0       = {leftover[1:0], data_byte[7:4]};
        s1       = {data_byte[3:0], 2'b00};
        last_idx = is_final ? 2'd2 : 2'd0;
      end
      default: begin
        s0       = {leftover[3:0], data_byte[7:6]};
        s1       = data_byte[5:0];
        last_idx = 2'd1;
      end
    endcase

    if (stopped || stop_now) begin
      push_job.chars[0] = NO_CHAR;
      push_job.trunc    = 1'b1;
      push_job.is_last  = 1'b1;
    end else begin
      push_job.chars[0] = sym(s0);
      push_job.chars[1] = sym(s1);
      push_job.chars[2] = PAD_CHAR;
      push_job.chars[3] = PAD_CHAR;
      push_job.last_idx = last_idx;
    end

    if (accept) begin
      if (stopped || stop_now) begin
        push         = is_final;
        stopped_next = !is_final;
        if (is_final) begin
          phase_next    = PHASE_FIRST;
          leftover_next = '0;
          cnt_next      = '0;
        end
      end else begin
        push = 1'b1;
        if (is_final) begin
          phase_next    = PHASE_FIRST;
          leftover_next = '0;
          cnt_next      = '0;
        end else begin
          cnt_next = cnt + CNT_W'(last_idx) + CNT_W'(1);
          case (phase)
            PHASE_FIRST: begin
              phase_next    = PHASE_SECOND;
              leftover_next = {2'b00, data_byte[1:0]};
            end
            PHASE_SECOND: begin
              phase_next    = PHASE_THIRD;
              leftover_next = data_byte[3:0];
            end
            default: begin
              phase_next    = PHASE_FIRST;
              leftover_next = '0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= OUT_LIMIT_RESET;
      phase     <= PHASE_FIRST;
      leftover  <= '0;
      cnt       <= '0;
      stopped   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        out_limit <= cfg_wr_data;
      end
      phase    <= phase_next;
      leftover <= leftover_next;
      cnt      <= cnt_next;
      stopped  <= stopped_next;
    end
  end

endmodule

FILE: rtl/core/b64enc_queue.sv
// ----------------------------------------------------------------------------
// b64enc_queue
// Two-entry request queue between the byte front end and the character
// back end.
// ----------------------------------------------------------------------------
module b64enc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  b64enc_pkg::job_t      push_job,
  input  logic                  pop,
  output b64enc_pkg::job_t      head,
  output b64enc_pkg::q_status_t q_stat
);
  import b64enc_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign q_stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = entries[rd_ptr];

  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/b64enc_back.sv
// ----------------------------------------------------------------------------
// b64enc_back
// Drains queued requests into a registered output, one character per cycle when not stalled.
// ----------------------------------------------------------------------------
module b64enc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  b64enc_pkg::job_t              head,
  input  b64enc_pkg::q_status_t         q_stat,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [b64enc_pkg::CHAR_W-1:0] char_code,
  output logic                          char_valid,
  output logic                          run_end,
  output logic                          truncated
);
  import b64enc_pkg::*;

  job_t             job;
  logic             job_valid;
  logic [IDX_W-1:0] idx;
  logic             emit, job_done;

  assign emit     = job_valid && (!out_valid || out_ready);
  assign job_done = emit && (idx == job.last_idx);
  assign pop      = !q_stat.empty && (!job_valid || job_done);

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    if (emit) begin
      char_code  <= job.chars[idx];
      char_valid <= !job.trunc;
      run_end    <= job.is_last && (idx == job.last_idx);
      truncated  <= job.trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        job_valid <= 1'b1;
        idx       <= '0;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end else if (emit) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/base64_stream_encoder_top.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming base64 encoder with output length limit and '=' padding.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  input    in_valid/in_ready     data_byte, is_final
//  output   out_valid/out_ready   char_code, char_valid, run_end, truncated
//  config   cfg_wr_en             cfg_wr_data (out_limit)
//
//  A byte is taken whenever the two-entry request queue has room.
//  The character back end emits one result per cycle while out_ready does not
//  stall it; a byte yields up to 4 characters, 4/3 on average in a long string.
//  Synchronous reset clears all string state and restores out_limit to 128.
//  Output stalls back up through the queue; the front holds in_ready low when
//  the queue is full.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top #(
  parameter int unsigned MAX_OUT_LIMIT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [b64enc_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          is_final,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [b64enc_pkg::CHAR_W-1:0] char_code,
  output logic                          char_valid,
  output logic                          run_end,
  output logic                          truncated
);
  import b64enc_pkg::*;

  job_t      push_job, head;
  q_status_t q_stat;
  logic      push, pop;

  b64enc_front #(
    .MAX_OUT_LIMIT(MAX_OUT_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .is_final   (is_final),
    .q_stat     (q_stat),
    .push       (push),
    .push_job   (push_job)
  );

  b64enc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  b64enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .char_valid(char_valid),
    .run_end   (run_end),
    .truncated (truncated)
  );

`ifndef SYNTHESIS
  a_reset_clears : assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("outputs not idle after reset");

  a_trunc_form : assert property (@(posedge clk) disable iff (rst)
    (out_valid && truncated) |-> (!char_valid && run_end && char_code == NO_CHAR))
    else $error("malformed truncation result");

  a_invalid_only_trunc : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !char_valid) |-> truncated)
    else $error("non-valid character outside truncation");
`endif

endmodule
